@@ sv/polyline_arc_length_tex_coords_assert.svh @@
`ifndef POLYLINE_ARC_LENGTH_TEX_COORDS_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_TEX_COORDS_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PALT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PALT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/palt_pkg.sv @@
package palt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               is_control;
    logic               auto_texture;
    logic signed [31:0] anchor_coord;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   vertex_index;
    logic signed [31:0] tex_u;
    logic               overflowed;
    logic               last_result;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } iter_cmd_t;

endpackage

@@ sv/palt_iter.sv @@
module palt_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  palt_pkg::iter_cmd_t cmd_i,
  input  logic [65:0]         opa_i,
  input  logic [38:0]         opb_i,
  output logic                done_o,
  output logic [65:0]         res_o
);
  import palt_pkg::*;

  localparam logic [5:0] ITERS = 6'd33;

  logic [5:0]  cnt_q;
  logic        done_q;
  op_e         op_q;
  logic [65:0] acc_q, mc_q;
  logic [32:0] mp_q;
  logic [65:0] rad_q;
  logic [34:0] srem_q;
  logic [32:0] root_q;
  logic [39:0] drem_q;
  logic [38:0] den_q;
  logic [32:0] quo_q;

  logic [36:0] sr_n, strial, sdiff;
  logic        sge;
  logic [39:0] dsh, ddiff;
  logic        dge;

  always_comb begin
    sr_n   = {srem_q, rad_q[65:64]};
    strial = {2'b00, root_q, 2'b01};
    sge    = (sr_n >= strial);
    sdiff  = sr_n - strial;
    dsh    = (cnt_q == ITERS) ? drem_q : {drem_q[38:0], 1'b0};
    dge    = (dsh >= {1'b0, den_q});
    ddiff  = dsh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (cmd_i.start) begin
        cnt_q <= ITERS;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      acc_q  <= '0;
      mc_q   <= {33'd0, opa_i[32:0]};
      mp_q   <= opb_i[32:0];
      rad_q  <= opa_i;
      srem_q <= '0;
      root_q <= '0;
      drem_q <= {1'b0, opa_i[38:0]};
      den_q  <= opb_i;
      quo_q  <= '0;
    end else if (cnt_q != '0) begin
      acc_q  <= mp_q[0] ? acc_q + mc_q : acc_q;
      mc_q   <= {mc_q[64:0], 1'b0};
      mp_q   <= {1'b0, mp_q[32:1]};
      rad_q  <= {rad_q[63:0], 2'b00};
      srem_q <= sge ? sdiff[34:0] : sr_n[34:0];
      root_q <= {root_q[31:0], sge};
      drem_q <= dge ? ddiff : dsh;
      quo_q  <= {quo_q[31:0], dge};
    end
  end

  always_comb begin
    unique case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_SQRT: res_o = {33'd0, root_q};
      OP_DIV:  res_o = {33'd0, quo_q};
      default: res_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

@@ sv/polyline_arc_length_tex_coords.sv @@
// Texture coordinates by arc length for a closed polyline.
// Input channel (in_valid_i, in_stall_o, in_word_i): one word per vertex, taken
// at one word per cycle while the block is loading. The word with last_vertex
// set closes the loop; in_stall_o then stays high until every result is taken.
// Up to 64 vertices are kept; later ones are dropped and flagged in overflowed.
// Output channel (out_valid_o, out_stall_i, out_word_o): one word per stored
// vertex, in index order, last_result set on the final one.
// After the last vertex, each segment takes three address steps, then two serial
// squarings and a serial square root; each run between anchors then sums its
// segment lengths, and each vertex takes a serial division and a serial
// multiplication, then one update step. Results then leave one word at a time;
// each is read, registered and held until the receiver takes it.
// A single shared bit-serial unit does all multiplications, roots and divisions.
// While the receiver stalls, the output word holds and the block waits.
// Reset empties the loop; the vertex memories are not cleared.
module polyline_arc_length_tex_coords (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  palt_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output palt_pkg::out_word_t out_word_o
);
  import palt_pkg::*;

  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_SEG_A   = 5'd1;
  localparam logic [4:0] ST_SEG_B   = 5'd2;
  localparam logic [4:0] ST_SEG_C   = 5'd3;
  localparam logic [4:0] ST_SQX     = 5'd4;
  localparam logic [4:0] ST_SQY     = 5'd5;
  localparam logic [4:0] ST_ROOT    = 5'd6;
  localparam logic [4:0] ST_RUN0    = 5'd7;
  localparam logic [4:0] ST_TOT_RD  = 5'd8;
  localparam logic [4:0] ST_TOT_ADD = 5'd9;
  localparam logic [4:0] ST_CS      = 5'd10;
  localparam logic [4:0] ST_CE      = 5'd11;
  localparam logic [4:0] ST_CE2     = 5'd12;
  localparam logic [4:0] ST_CO_DIV  = 5'd13;
  localparam logic [4:0] ST_CO_MUL  = 5'd14;
  localparam logic [4:0] ST_CO_ADD  = 5'd15;
  localparam logic [4:0] ST_OUT_RD  = 5'd16;
  localparam logic [4:0] ST_OUT_W   = 5'd17;
  localparam logic [4:0] ST_OUT_H   = 5'd18;

  logic [4:0]            state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  ovf_q;
  logic [MAX_VERTICES-1:0] flags_q;
  logic [IDX_W-1:0]      i_q, l_q, s_q, e_q, a0_q;
  logic                  found_q, noanch_q;
  logic [38:0]           total_q, part_q;
  logic signed [31:0]    xa_q, ya_q;
  logic [32:0]           dy_q;
  logic [65:0]           sq_q;
  logic signed [32:0]    cs_q;
  logic [32:0]           mag_q;
  logic                  neg_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  logic [31:0] xmem [MAX_VERTICES];
  logic [31:0] ymem [MAX_VERTICES];
  logic [31:0] cmem [MAX_VERTICES];
  logic [32:0] smem [MAX_VERTICES];
  logic [31:0] umem [MAX_VERTICES];
  logic [31:0] xr_q, yr_q, cr_q, ur_q;
  logic [32:0] sr_q;

  iter_cmd_t   cmd;
  logic [65:0] opa;
  logic [38:0] opb;
  logic        it_done;
  logic [65:0] it_res;

  palt_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (it_done),
    .res_o  (it_res)
  );

  logic             in_acc, wr_load;
  logic [IDX_W-1:0] nxt_i, nxt_l, xaddr, caddr;
  logic             i_last, l_last, anc_nl, f_now;
  logic [IDX_W-1:0] a0_n;
  logic signed [32:0] dxs, dys;
  logic [66:0]      sum2, rnd;
  logic [34:0]      off;
  logic signed [35:0] rwide;
  logic [31:0]      rsat;
  logic signed [32:0] cev, csv, dlt;
  logic [38:0]      part_n;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign wr_load = in_acc && !cnt_q[CNT_W-1];
  assign in_stall_o = (state_q != ST_LOAD);

  always_comb begin
    i_last = ({1'b0, i_q} + 7'd1 == cnt_q);
    l_last = ({1'b0, l_q} + 7'd1 == cnt_q);
    nxt_i  = i_last ? '0 : i_q + 6'd1;
    nxt_l  = l_last ? '0 : l_q + 6'd1;
    anc_nl = noanch_q ? (nxt_l == '0) : flags_q[nxt_l];
    f_now  = flags_q[i_q];
    a0_n   = (!found_q && f_now) ? i_q : a0_q;
    xaddr  = (state_q == ST_SEG_B) ? nxt_i : i_q;
    caddr  = (state_q == ST_CE) ? e_q : s_q;
    dxs    = {xa_q[31], xa_q} - {xr_q[31], xr_q};
    dys    = {ya_q[31], ya_q} - {yr_q[31], yr_q};
    sum2   = {1'b0, sq_q} + {1'b0, it_res};
    rnd    = {1'b0, it_res} + 67'h80000000;
    off    = rnd[66:32];
    rwide  = neg_q ? {{3{cs_q[32]}}, cs_q} - $signed({1'b0, off})
                   : {{3{cs_q[32]}}, cs_q} + $signed({1'b0, off});
    if (rwide > 36'sh07FFFFFFF) begin
      rsat = 32'h7FFFFFFF;
    end else if (rwide < -36'sh080000000) begin
      rsat = 32'h80000000;
    end else begin
      rsat = rwide[31:0];
    end
    csv    = noanch_q ? 33'sd0 : cs_q;
    cev    = noanch_q ? 33'sd65536 : {cr_q[31], cr_q};
    dlt    = cev - csv;
    part_n = part_q + {6'd0, sr_q};
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state_q)
      ST_SEG_C: begin
        cmd.start = 1'b1;
        opa = {33'd0, (dxs < 0) ? -dxs : dxs};
        opb = {6'd0, (dxs < 0) ? -dxs : dxs};
      end
      ST_SQX: begin
        cmd.start = it_done;
        opa = {33'd0, dy_q};
        opb = {6'd0, dy_q};
      end
      ST_SQY: begin
        cmd.start = it_done;
        cmd.op    = OP_SQRT;
        opa = sum2[65:0];
      end
      ST_CE2: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        opa = '0;
        opb = (total_q == '0) ? 39'd1 : total_q;
      end
      ST_CO_DIV: begin
        cmd.start = it_done;
        opa = {33'd0, it_res[32:0]};
        opb = {6'd0, mag_q};
      end
      ST_CO_ADD: begin
        cmd.start = !(nxt_l == e_q);
        cmd.op    = OP_DIV;
        opa = {27'd0, part_n};
        opb = total_q;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_load) begin
      xmem[cnt_q[IDX_W-1:0]] <= in_word_i.pos_x;
      ymem[cnt_q[IDX_W-1:0]] <= in_word_i.pos_y;
      cmem[cnt_q[IDX_W-1:0]] <= in_word_i.anchor_coord;
    end
    xr_q <= xmem[xaddr];
    yr_q <= ymem[xaddr];
    cr_q <= cmem[caddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT && it_done) begin
      smem[i_q] <= it_res[32:0];
    end
    sr_q <= smem[l_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CO_MUL && it_done) begin
      umem[l_q] <= rsat;
    end
    ur_q <= umem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_load) begin
      flags_q[cnt_q[IDX_W-1:0]] <= in_word_i.is_control && !in_word_i.auto_texture;
    end
    unique case (state_q)
      ST_SEG_B: begin
        xa_q <= xr_q;
        ya_q <= yr_q;
      end
      ST_SEG_C: begin
        dy_q <= (dys < 0) ? 33'(-dys) : 33'(dys);
      end
      ST_SQX: begin
        if (it_done) begin
          sq_q <= it_res;
        end
      end
      ST_CE: begin
        cs_q <= {cr_q[31], cr_q};
      end
      ST_CE2: begin
        cs_q  <= csv;
        neg_q <= dlt < 0;
        mag_q <= (dlt < 0) ? 33'(-dlt) : 33'(dlt);
        if (total_q == '0) begin
          total_q <= 39'd1;
        end
        part_q <= '0;
        l_q    <= s_q;
      end
      ST_CO_ADD: begin
        part_q <= part_n;
      end
      default: begin
      end
    endcase
    if (state_q == ST_RUN0) begin
      total_q <= '0;
      l_q     <= s_q;
    end else if (state_q == ST_TOT_ADD) begin
      total_q <= total_q + {6'd0, sr_q};
      if (!anc_nl) begin
        l_q <= nxt_l;
      end
    end else if (state_q == ST_CO_ADD) begin
      l_q <= nxt_l;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      s_q         <= '0;
      e_q         <= '0;
      a0_q        <= '0;
      found_q     <= 1'b0;
      noanch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (!cnt_q[CNT_W-1]) begin
              cnt_q <= cnt_q + 7'd1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_word_i.last_vertex) begin
              state_q <= ST_SEG_A;
              i_q     <= '0;
              a0_q    <= '0;
              found_q <= 1'b0;
            end
          end
        end
        ST_SEG_A: state_q <= ST_SEG_B;
        ST_SEG_B: state_q <= ST_SEG_C;
        ST_SEG_C: state_q <= ST_SQX;
        ST_SQX: begin
          if (it_done) begin
            state_q <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (it_done) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (it_done) begin
            a0_q    <= a0_n;
            found_q <= found_q || f_now;
            if (i_last) begin
              s_q      <= a0_n;
              noanch_q <= !(found_q || f_now);
              state_q  <= ST_RUN0;
            end else begin
              i_q     <= nxt_i;
              state_q <= ST_SEG_A;
            end
          end
        end
        ST_RUN0:   state_q <= ST_TOT_RD;
        ST_TOT_RD: state_q <= ST_TOT_ADD;
        ST_TOT_ADD: begin
          if (anc_nl) begin
            e_q     <= nxt_l;
            state_q <= ST_CS;
          end else begin
            state_q <= ST_TOT_RD;
          end
        end
        ST_CS:  state_q <= ST_CE;
        ST_CE:  state_q <= ST_CE2;
        ST_CE2: state_q <= ST_CO_DIV;
        ST_CO_DIV: begin
          if (it_done) begin
            state_q <= ST_CO_MUL;
          end
        end
        ST_CO_MUL: begin
          if (it_done) begin
            state_q <= ST_CO_ADD;
          end
        end
        ST_CO_ADD: begin
          if (nxt_l == e_q) begin
            s_q <= e_q;
            if (e_q == a0_q) begin
              i_q     <= '0;
              state_q <= ST_OUT_RD;
            end else begin
              state_q <= ST_RUN0;
            end
          end else begin
            state_q <= ST_CO_DIV;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_W;
        ST_OUT_W: begin
          out_q.vertex_index <= i_q;
          out_q.tex_u        <= ur_q;
          out_q.overflowed   <= ovf_q;
          out_q.last_result  <= i_last;
          out_valid_q        <= 1'b1;
          state_q            <= ST_OUT_H;
        end
        ST_OUT_H: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (out_q.last_result) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              i_q     <= nxt_i;
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`include "polyline_arc_length_tex_coords_assert.svh"

  `PALT_ASSERT_IMPL(a_no_out_in_load, !in_stall_o, !out_valid_q, "result pending while loading")
  `PALT_ASSERT_NEXT(a_back_to_load, out_valid_o && !out_stall_i && out_word_o.last_result,
                    !in_stall_o, "block did not return to loading after the last word")
  `PALT_ASSERT_IMPL(a_cnt_cap, in_acc, cnt_q <= 7'd64, "vertex count beyond capacity")
  `PALT_ASSERT_IMPL(a_ovf_match, out_valid_o, out_word_o.overflowed == ovf_q,
                    "overflow flag differs from stored flag")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import palt_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  polyline_arc_length_tex_coords u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  in_word_t  vertex_queue[$];
  out_word_t coord_queue[$];

  logic [31:0] loop_x[MAX_VERTICES];
  logic [31:0] loop_y[MAX_VERTICES];
  logic        loop_anchor[MAX_VERTICES];
  logic [31:0] loop_coord[MAX_VERTICES];
  int          loop_count;
  logic        loop_overflow;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int words_checked;
  int loops_sent;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [63:0] abs_diff(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    abs_diff = (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [63:0] isqrt65(logic [64:0] v);
    logic [66:0] rem;
    logic [66:0] trial;
    logic [63:0] root;
    logic [1:0]  pair;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      pair  = (i == 32) ? {1'b0, v[64]} : v[2*i +: 2];
      rem   = {rem[64:0], pair};
      trial = {1'b0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    isqrt65 = root;
  endfunction

  function automatic logic [63:0] segment_length(int a, int b);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = abs_diff(loop_x[a], loop_x[b]);
    dy = abs_diff(loop_y[a], loop_y[b]);
    segment_length = isqrt65({1'b0, dx * dx} + {1'b0, dy * dy});
  endfunction

  function automatic logic [32:0] length_ratio(logic [63:0] p, logic [63:0] total);
    logic [127:0] num;
    num = {32'b0, p, 32'b0};
    length_ratio = 33'(num / {64'b0, total});
  endfunction

  function automatic logic [31:0] blend_coord(longint cs, longint ce, logic [32:0] t);
    longint       delta;
    logic [63:0]  mag;
    logic [127:0] prod;
    longint       off;
    longint       r;
    delta = ce - cs;
    mag   = (delta < 0) ? 64'(-delta) : 64'(delta);
    prod  = {95'b0, t} * {64'b0, mag} + 128'h8000_0000;
    off   = longint'(prod[95:32]);
    r     = (delta < 0) ? cs - off : cs + off;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    blend_coord = r[31:0];
  endfunction

  task automatic predict_vertex(input in_word_t w);
    int          anchors[$];
    longint      coord[MAX_VERTICES];
    int          n;
    int          s;
    int          e;
    longint      cs;
    longint      ce;
    logic [63:0] total;
    logic [63:0] part;
    bit          no_anchor;
    out_word_t   r;
    if (loop_count < MAX_VERTICES) begin
      loop_x[loop_count]      = w.pos_x;
      loop_y[loop_count]      = w.pos_y;
      loop_anchor[loop_count] = w.is_control && !w.auto_texture;
      loop_coord[loop_count]  = w.anchor_coord;
      loop_count++;
    end else begin
      loop_overflow = 1'b1;
    end
    if (!w.last_vertex) return;
    n = loop_count;
    for (int i = 0; i < n; i++) if (loop_anchor[i]) anchors.insert(anchors.size(), i);
    no_anchor = (anchors.size() == 0);
    if (no_anchor) anchors.insert(0, 0);
    for (int i = 0; i < anchors.size(); i++) begin
      s = anchors[i];
      e = anchors[(i + 1 < anchors.size()) ? i + 1 : 0];
      if (no_anchor) begin
        cs = 0;
        ce = 65536;
      end else begin
        cs = longint'($signed(loop_coord[s]));
        ce = longint'($signed(loop_coord[e]));
      end
      if (e <= s) e += n;
      total = 0;
      for (int l = s; l < e; l++) total += segment_length(l % n, (l + 1) % n);
      if (total == 0) total = 1;
      part = 0;
      for (int l = s; l < e; l++) begin
        coord[l % n] = longint'($signed(blend_coord(cs, ce, length_ratio(part, total))));
        part += segment_length(l % n, (l + 1) % n);
      end
    end
    for (int i = 0; i < n; i++) begin
      r.vertex_index = i[IDX_W-1:0];
      r.tex_u        = coord[i][31:0];
      r.overflowed   = loop_overflow;
      r.last_result  = (i + 1 == n);
      coord_queue.insert(coord_queue.size(), r);
    end
    loop_count    = 0;
    loop_overflow = 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: pick_coord = 32'h8000_0000;
      1: pick_coord = 32'h7FFF_FFFF;
      2: pick_coord = 32'h0000_0000;
      3, 4, 5: pick_coord = 32'($signed($urandom_range(0, 2000000)) - 1000000);
      6, 7: pick_coord = 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
      default: pick_coord = $urandom;
    endcase
  endfunction

  task automatic queue_loop(input int n, input int anchor_pct);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.pos_x        = pick_coord();
      w.pos_y        = pick_coord();
      w.is_control   = ($urandom_range(0, 99) < anchor_pct + 20);
      w.auto_texture = ($urandom_range(0, 99) >= anchor_pct);
      w.anchor_coord = pick_coord();
      w.last_vertex  = (i == n - 1);
      vertex_queue.insert(vertex_queue.size(), w);
    end
    loops_sent++;
  endtask

  task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y, input logic c,
                              input logic a, input logic [31:0] u, input logic last);
    in_word_t w;
    w.pos_x        = x;
    w.pos_y        = y;
    w.is_control   = c;
    w.auto_texture = a;
    w.anchor_coord = u;
    w.last_vertex  = last;
    vertex_queue.insert(vertex_queue.size(), w);
    if (last) loops_sent++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) predict_vertex(in_word_i);
      if (vertex_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i  <= vertex_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_word;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_checked++;
        if (coord_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: index %0d tex_u %h", out_word_o.vertex_index,
                     out_word_o.tex_u);
        end else begin
          exp_word = coord_queue.pop_front();
          if (out_word_o !== exp_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: exp idx %0d u %h ovf %b last %b, got %0d %h %b %b",
                       exp_word.vertex_index, exp_word.tex_u, exp_word.overflowed,
                       exp_word.last_result, out_word_o.vertex_index, out_word_o.tex_u,
                       out_word_o.overflowed, out_word_o.last_result);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    in_word_t w;
    rst_ni        = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 58;
    mismatches    = 0;
    words_checked = 0;
    loops_sent    = 0;
    loop_count    = 0;
    loop_overflow = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1);
    queue_vertex(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h1234_0000, 1'b0);
    queue_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h0, 1'b0);
    queue_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b1);
    queue_vertex(32'h0001_0000, 32'h0, 1'b1, 1'b0, 32'h8000_0000, 1'b0);
    queue_vertex(32'h0002_0000, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
    queue_vertex(32'h0003_0000, 32'h0, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0);
    queue_vertex(32'h0003_0000, 32'h0003_0000, 1'b0, 1'b0, 32'h0, 1'b1);
    queue_vertex(32'h5, 32'h5, 1'b1, 1'b0, 32'h0001_0000, 1'b0);
    queue_vertex(32'h5, 32'h5, 1'b1, 1'b0, 32'hFFFF_0000, 1'b0);
    queue_vertex(32'h5, 32'h5, 1'b0, 1'b1, 32'h0, 1'b1);
    queue_vertex(32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0);
    queue_vertex(32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b1);
    for (int i = 0; i < 70; i++) begin
      w.pos_x        = $urandom;
      w.pos_y        = $urandom;
      w.is_control   = (i % 9 == 0);
      w.auto_texture = (i % 18 == 0);
      w.anchor_coord = $urandom;
      w.last_vertex  = (i == 69);
      vertex_queue.insert(vertex_queue.size(), w);
    end
    loops_sent++;
    while (vertex_queue.size() > 0 || coord_queue.size() > 0 || loop_count > 0)
      @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 21 : 0;
      for (int k = 0; k < 4; k++)
        queue_loop($urandom_range(1, 12), $urandom_range(0, 60));
      if (phase == 2) queue_loop(64, 30);
      while (vertex_queue.size() > 0 || coord_queue.size() > 0 || loop_count > 0)
        @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d loops; checked %0d result words, including overflow and anchor cases.",
             loops_sent, words_checked);
    if (mismatches == 0 && coord_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, coord_queue.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d words outstanding", coord_queue.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
